// File: hdl/tree_leaf_reach_mask_core_defines.svh
// Assertion macros for the tree leaf reach mask core.
`ifndef TREE_LEAF_REACH_MASK_CORE_DEFINES_SVH
`define TREE_LEAF_REACH_MASK_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define TLRM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define TLRM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/tlrm_pkg.sv
// Shared types and constants for the tree leaf reach mask core.
package tlrm_pkg;

  localparam logic [1:0] OP_LOAD_NODE   = 2'd0;
  localparam logic [1:0] OP_LOAD_SPLIT  = 2'd1;
  localparam logic [1:0] OP_LOAD_SAMPLE = 2'd2;
  localparam logic [1:0] OP_EVALUATE    = 2'd3;

  localparam int LEAF_CNT_W = 6;
  localparam int MASK_W     = 32;
  localparam int FEAT_NUM_W = 6;
  localparam int BIN_NUM_W  = 5;
  localparam int SLOT_W     = 6;
  localparam int DATUM_W    = 32;
  localparam int SPLIT_AW   = FEAT_NUM_W + BIN_NUM_W;

  typedef struct packed {
    logic                  leaf;
    logic                  owned;
    logic [FEAT_NUM_W-1:0] feat;
    logic [BIN_NUM_W-1:0]  bin;
  } node_ent_t;

  typedef struct packed {
    logic load_node;
    logic load_split;
    logic load_sample;
    logic start;
    logic issue;
    logic capture;
  } cmd_t;

  typedef struct packed {
    logic issue_last;
    logic busy;
  } stat_t;

endpackage

// File: hdl/tlrm_in_if.sv
// Input channel of the tree leaf reach mask core.
interface tlrm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [5:0]  node_slot;
  logic        leaf_flag;
  logic        owned_here;
  logic [5:0]  feature_num;
  logic [4:0]  bin_num;
  logic signed [31:0] datum;

  modport source (output valid, op, node_slot, leaf_flag, owned_here, feature_num, bin_num,
                  datum, input ready);
  modport sink (input valid, op, node_slot, leaf_flag, owned_here, feature_num, bin_num,
                datum, output ready);
endinterface

// File: hdl/tlrm_out_if.sv
// Result channel of the tree leaf reach mask core.
interface tlrm_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] leaf_mask;
  logic [5:0]  leaf_total;

  modport source (output valid, leaf_mask, leaf_total, input ready);
  modport sink (input valid, leaf_mask, leaf_total, output ready);
endinterface

// File: hdl/tree_leaf_reach_mask_core.sv
// Top level of the tree leaf reach mask core: controller, datapath and checks.
//
//   channel   direction  handshake      payload
//   in_if     sink       valid/ready    op, node_slot, leaf_flag, owned_here,
//                                       feature_num, bin_num, datum
//   out_if    source     valid/ready    leaf_mask, leaf_total
//
// Loads produce no result. During an evaluate one node per cycle goes through
// node read, sample/split read and compare.
// Reset is synchronous and clears only control; tables are undefined until loaded.
// A result waits in the output register while further transactions are taken;
// a finished evaluate holds until that register is free.
`include "tree_leaf_reach_mask_core_defines.svh"

module tree_leaf_reach_mask_core #(
  parameter int TREE_DEPTH    = 5,
  parameter int FEATURE_COUNT = 64,
  parameter int BIN_COUNT     = 32
) (
  input logic         clk,
  input logic         rst_n,
  tlrm_in_if.sink     in_if,
  tlrm_out_if.source  out_if
);
  import tlrm_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  tlrm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_op     (in_if.op),
    .in_ready  (in_if.ready),
    .out_ready (out_if.ready),
    .out_valid (out_if.valid),
    .stat      (stat),
    .cmd       (cmd)
  );

  tlrm_dpath #(
    .TREE_DEPTH    (TREE_DEPTH),
    .FEATURE_COUNT (FEATURE_COUNT),
    .BIN_COUNT     (BIN_COUNT)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_node_slot   (in_if.node_slot),
    .in_leaf_flag   (in_if.leaf_flag),
    .in_owned_here  (in_if.owned_here),
    .in_feature_num (in_if.feature_num),
    .in_bin_num     (in_if.bin_num),
    .in_datum       (in_if.datum),
    .out_leaf_mask  (out_if.leaf_mask),
    .out_leaf_total (out_if.leaf_total)
  );

  `TLRM_ASSERT_IMP(a_capture_drained, cmd.capture, !stat.busy, "capture with walk in flight")
  `TLRM_ASSERT_IMP(a_start_drained, cmd.start, !stat.busy, "evaluate started over a walk")
  `TLRM_ASSERT_NXT(a_capture_valid, cmd.capture, out_if.valid, "captured result not presented")
  `TLRM_ASSERT_IMP(a_no_load_in_walk, cmd.issue, !(cmd.load_node || cmd.load_split || cmd.load_sample), "table load during walk")

endmodule

// File: hdl/tlrm_ctrl.sv
// Controller: transaction decode, evaluation sequencing and result handoff.
module tlrm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [1:0]        in_op,
  output logic              in_ready,
  input  logic              out_ready,
  output logic              out_valid,
  input  tlrm_pkg::stat_t   stat,
  output tlrm_pkg::cmd_t    cmd
);
  import tlrm_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       in_fire;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_op)
            OP_LOAD_NODE:   cmd.load_node   = 1'b1;
            OP_LOAD_SPLIT:  cmd.load_split  = 1'b1;
            OP_LOAD_SAMPLE: cmd.load_sample = 1'b1;
            OP_EVALUATE: begin
              cmd.start = 1'b1;
              state_nxt = ST_RUN;
            end
            default: ;
          endcase
        end
      end
      ST_RUN: begin
        cmd.issue = 1'b1;
        if (stat.issue_last) state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (!stat.busy && (!out_valid_r || out_ready)) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid_nxt = cmd.capture || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: hdl/tlrm_dpath.sv
// Datapath: node, split and sample tables plus the three-stage tree walk.
module tlrm_dpath #(
  parameter int TREE_DEPTH    = 5,
  parameter int FEATURE_COUNT = 64,
  parameter int BIN_COUNT     = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  tlrm_pkg::cmd_t             cmd,
  output tlrm_pkg::stat_t            stat,
  input  logic [5:0]                 in_node_slot,
  input  logic                       in_leaf_flag,
  input  logic                       in_owned_here,
  input  logic [5:0]                 in_feature_num,
  input  logic [4:0]                 in_bin_num,
  input  logic signed [31:0]         in_datum,
  output logic [31:0]                out_leaf_mask,
  output logic [5:0]                 out_leaf_total
);
  import tlrm_pkg::*;

  localparam int NODE_COUNT  = (1 << (TREE_DEPTH + 1)) - 1;
  localparam int INNER_COUNT = (1 << TREE_DEPTH) - 1;
  localparam int NIDX_W      = $clog2(NODE_COUNT);
  localparam int SPLIT_DEPTH = FEATURE_COUNT * BIN_COUNT;
  localparam int FEAT_W      = (FEATURE_COUNT > 1) ? $clog2(FEATURE_COUNT) : 1;
  localparam int SADDR_W     = (SPLIT_DEPTH > 1) ? $clog2(SPLIT_DEPTH) : 1;

  node_ent_t          node_mem [NODE_COUNT];
  logic [DATUM_W-1:0] split_mem [SPLIT_DEPTH];
  logic [DATUM_W-1:0] sample_mem [FEATURE_COUNT];

  // issue stage
  logic [NIDX_W-1:0] idx_r;
  // stage 1
  logic              s1_valid_r;
  logic [NIDX_W-1:0] s1_idx_r;
  node_ent_t         node_q_r;
  // stage 2
  logic               s2_valid_r;
  logic [NIDX_W-1:0]  s2_idx_r;
  node_ent_t          s2_node_r;
  logic               s2_ok_r;
  logic [DATUM_W-1:0] samp_q_r;
  logic [DATUM_W-1:0] split_q_r;
  // walk state
  logic [NODE_COUNT-1:0] reach_r;
  logic [MASK_W-1:0]     mask_r;
  logic [LEAF_CNT_W-1:0] leaves_r;
  logic [MASK_W-1:0]     res_mask_r;
  logic [LEAF_CNT_W-1:0] res_total_r;

  logic                wr_slot_ok, wr_feat_ok, wr_bin_ok;
  logic [SPLIT_AW-1:0] wr_addr_full;
  logic                s1_feat_ok, s1_bin_ok;
  logic [SPLIT_AW-1:0] s1_addr_full;
  logic                reached, has_kids, le, go_left, go_right;
  logic [NIDX_W-1:0]   left_idx, right_idx;

  // table loads
  assign wr_slot_ok   = in_node_slot < SLOT_W'(NODE_COUNT);
  assign wr_feat_ok   = {1'b0, in_feature_num} < (FEAT_NUM_W + 1)'(FEATURE_COUNT);
  assign wr_bin_ok    = {1'b0, in_bin_num} < (BIN_NUM_W + 1)'(BIN_COUNT);
  assign wr_addr_full = SPLIT_AW'(in_feature_num) * SPLIT_AW'(BIN_COUNT)
                        + SPLIT_AW'(in_bin_num);

  always_ff @(posedge clk) begin
    if (cmd.load_node && wr_slot_ok) begin
      node_mem[in_node_slot[NIDX_W-1:0]] <= '{in_leaf_flag, in_owned_here,
                                             in_feature_num, in_bin_num};
    end
    if (cmd.issue) node_q_r <= node_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_split && wr_feat_ok && wr_bin_ok) begin
      split_mem[wr_addr_full[SADDR_W-1:0]] <= in_datum;
    end
    if (s1_valid_r) split_q_r <= split_mem[s1_addr_full[SADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_sample && wr_feat_ok) sample_mem[in_feature_num[FEAT_W-1:0]] <= in_datum;
    if (s1_valid_r) samp_q_r <= sample_mem[node_q_r.feat[FEAT_W-1:0]];
  end

  // stage 1: operand address
  assign s1_feat_ok   = {1'b0, node_q_r.feat} < (FEAT_NUM_W + 1)'(FEATURE_COUNT);
  assign s1_bin_ok    = {1'b0, node_q_r.bin} < (BIN_NUM_W + 1)'(BIN_COUNT);
  assign s1_addr_full = SPLIT_AW'(node_q_r.feat) * SPLIT_AW'(BIN_COUNT)
                        + SPLIT_AW'(node_q_r.bin);

  // stage 2: compare and mark children
  assign reached   = reach_r[s2_idx_r];
  assign has_kids  = s2_idx_r < NIDX_W'(INNER_COUNT);
  assign left_idx  = NIDX_W'({s2_idx_r, 1'b1});
  assign right_idx = left_idx + NIDX_W'(1);
  assign le        = $signed(samp_q_r) <= $signed(split_q_r);
  assign go_left   = !s2_node_r.owned || !s2_ok_r || le;
  assign go_right  = !s2_node_r.owned || (s2_ok_r && !le);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= cmd.issue;
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      idx_r <= '0;
    end else if (cmd.issue) begin
      idx_r <= idx_r + NIDX_W'(1);
    end
    s1_idx_r  <= idx_r;
    s2_idx_r  <= s1_idx_r;
    s2_node_r <= node_q_r;
    s2_ok_r   <= s1_feat_ok && s1_bin_ok;
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      reach_r  <= NODE_COUNT'(1);
      mask_r   <= '0;
      leaves_r <= '0;
    end else if (s2_valid_r) begin
      if (s2_node_r.leaf) begin
        if (!leaves_r[LEAF_CNT_W-1]) begin
          if (reached) mask_r[leaves_r[LEAF_CNT_W-2:0]] <= 1'b1;
          leaves_r <= leaves_r + LEAF_CNT_W'(1);
        end
      end else if (reached && has_kids) begin
        if (go_left) reach_r[left_idx] <= 1'b1;
        if (go_right) reach_r[right_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      res_mask_r  <= mask_r;
      res_total_r <= leaves_r;
    end
  end

  assign stat.issue_last = (idx_r == NIDX_W'(NODE_COUNT - 1));
  assign stat.busy       = s1_valid_r || s2_valid_r;
  assign out_leaf_mask   = res_mask_r;
  assign out_leaf_total  = res_total_r;

endmodule
